// File: design/cpse_pkg.sv
// Package for the cone pair steering estimator: fixed-point widths, register
// and case codes, the transaction payload types and the arctangent step table.
// Depends on nothing; every other design file uses it.
`default_nettype none
package cpse_pkg;

   localparam int COORD_FRAC_BITS = 4;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int GAIN_FRAC_BITS  = 24;
   localparam int ATAN_FRAC_BITS  = 16;
   localparam int CORDIC_STEPS    = 16;
   localparam int CORDIC_PRESCALE = 20;
   localparam int ATAN_DIVISOR    = 100;
   localparam int COORD_W         = 16;
   localparam int GAIN_W          = 24;
   localparam int DIM_W           = 12;
   localparam int ANGLE_W         = 17;
   localparam int CASE_W          = 3;
   localparam int ATAN_W          = 20;
   localparam int CORDIC_W        = 48;
   localparam int ADDR_W          = 5;

   typedef enum logic [2:0] {
      REG_GAIN_PAIR_CENTRE    = 3'd0,
      REG_GAIN_SAME_COLOUR    = 3'd1,
      REG_GAIN_ARCTANGENT     = 3'd2,
      REG_GAIN_SINGLE_KNOWN   = 3'd3,
      REG_GAIN_SINGLE_UNKNOWN = 3'd4,
      REG_FRAME_WIDTH         = 3'd5,
      REG_FLIP_HEIGHT         = 3'd6,
      REG_NEAR_LIMIT          = 3'd7
   } reg_index_type;

   typedef enum logic [CASE_W-1:0] {
      CASE_BOTH        = 3'd0,
      CASE_TWO_BLUE    = 3'd1,
      CASE_TWO_YELLOW  = 3'd2,
      CASE_BLUE_ONLY   = 3'd3,
      CASE_YELLOW_ONLY = 3'd4,
      CASE_NONE        = 3'd5
   } case_code_type;

   typedef struct packed {
      logic [COORD_W-1:0] blue_first_x;
      logic [COORD_W-1:0] blue_first_y;
      logic [COORD_W-1:0] blue_second_x;
      logic [COORD_W-1:0] blue_second_y;
      logic [COORD_W-1:0] yellow_first_x;
      logic [COORD_W-1:0] yellow_first_y;
      logic [COORD_W-1:0] yellow_second_x;
      logic [COORD_W-1:0] yellow_second_y;
   } frame_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] steer_angle;
      logic [CASE_W-1:0]         case_taken;
   } result_type;

   // atan(2^-i) in radians with 16 fraction bits.
   function automatic logic [16:0] atan_step(input logic [3:0] idx);
      logic [16:0] v;
      case (idx)
         4'd0:    v = 17'd51472;
         4'd1:    v = 17'd30386;
         4'd2:    v = 17'd16055;
         4'd3:    v = 17'd8150;
         4'd4:    v = 17'd4091;
         4'd5:    v = 17'd2047;
         4'd6:    v = 17'd1024;
         4'd7:    v = 17'd512;
         4'd8:    v = 17'd256;
         4'd9:    v = 17'd128;
         4'd10:   v = 17'd64;
         4'd11:   v = 17'd32;
         4'd12:   v = 17'd16;
         4'd13:   v = 17'd8;
         4'd14:   v = 17'd4;
         default: v = 17'd2;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: design/cpse_if.sv
// Valid/ready channel interfaces for the frame and result transactions.
// Depends on cpse_pkg for the payload types.
`default_nettype none
interface cpse_req_if;
   logic                       valid;
   logic                       ready;
   logic [cpse_pkg::COORD_W-1:0] blue_first_x;
   logic [cpse_pkg::COORD_W-1:0] blue_first_y;
   logic [cpse_pkg::COORD_W-1:0] blue_second_x;
   logic [cpse_pkg::COORD_W-1:0] blue_second_y;
   logic [cpse_pkg::COORD_W-1:0] yellow_first_x;
   logic [cpse_pkg::COORD_W-1:0] yellow_first_y;
   logic [cpse_pkg::COORD_W-1:0] yellow_second_x;
   logic [cpse_pkg::COORD_W-1:0] yellow_second_y;
   modport source (output valid, blue_first_x, blue_first_y, blue_second_x, blue_second_y,
                   yellow_first_x, yellow_first_y, yellow_second_x, yellow_second_y,
                   input ready);
   modport sink (input valid, blue_first_x, blue_first_y, blue_second_x, blue_second_y,
                 yellow_first_x, yellow_first_y, yellow_second_x, yellow_second_y,
                 output ready);
endinterface

interface cpse_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cpse_pkg::ANGLE_W-1:0] steer_angle;
   logic [cpse_pkg::CASE_W-1:0]         case_taken;
   modport source (output valid, steer_angle, case_taken, input ready);
   modport sink (input valid, steer_angle, case_taken, output ready);
endinterface
`default_nettype wire

// File: design/cpse_cordic.sv
// Iterative vectoring CORDIC: one shift/add/subtract step per cycle, 16 steps.
// Depends on cpse_pkg for widths and the arctangent step table.
`default_nettype none
module cpse_cordic (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [cpse_pkg::COORD_W:0]    num,
   input  wire logic signed [cpse_pkg::GAIN_W-1:0]   den,
   output logic                                      done,
   output logic signed [cpse_pkg::ATAN_W-1:0]        angle
);
   import cpse_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ATAN_W-1:0]   z_ff, z_in;
   logic [3:0]                 step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic signed [CORDIC_W-1:0] xs, ys, num_ext, den_ext;
   logic signed [ATAN_W-1:0]   step_angle;

   always_comb begin
      num_ext    = CORDIC_W'(num) <<< CORDIC_PRESCALE;
      den_ext    = CORDIC_W'(den) <<< CORDIC_PRESCALE;
      xs         = x_ff >>> step_ff;
      ys         = y_ff >>> step_ff;
      step_angle = ATAN_W'($signed({1'b0, atan_step(step_ff)}));
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         // Turn the vector so that its x part is positive.
         if (den < 0) begin
            x_in = -den_ext;
            y_in = -num_ext;
         end else begin
            x_in = den_ext;
            y_in = num_ext;
         end
         z_in    = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_angle;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_angle;
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("CORDIC restarted while busy");
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && step_ff == '0) else $error("CORDIC done with steps left");
   a_busy_counts: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> busy_ff || done_ff) else $error("CORDIC stopped early");
endmodule
`default_nettype wire

// File: design/cone_pair_steering_estimator.sv
// Top level of the cone pair steering estimator: APB-style register file,
// frame capture, case selection, shared multiplier, rounding and saturation.
// Depends on cpse_pkg, cpse_if and cpse_cordic.
//
// Use: a frame of up to two blue and two yellow cone centroids arrives as one
// transaction on req_ch; exactly one result transaction (steering angle and
// case number) leaves on rsp_ch for every frame. The block handles one frame
// at a time: req_ch.ready is high only while the block is idle, so a new
// frame is taken once the previous result has been collected.
// A frame passes through the setup, multiply, round and done states; in the
// two yellow cone case, when the pair differs in both x and y, the 16 step
// CORDIC runs in its iterative unit between setup and multiply. A frame
// occupies the block until the receiver has taken its result.
// When the receiver holds rsp_ch.ready low the result stays registered and
// stable, and no further frame is accepted until it has been taken.
// The user writes registers over the csr_ port (byte address 4*index) only
// while the block is idle; the block does not enforce it. Reads give the
// stored values. Synchronous reset restores defaults, forgets the learnt side.
`default_nettype none
module cone_pair_steering_estimator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cpse_req_if.sink                            req_ch,
   cpse_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [cpse_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import cpse_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SETUP, S_CORDIC, S_MUL, S_ROUND, S_DONE
   } state_type;

   localparam int PROD_W = 46;

   // Register file.
   logic [GAIN_W-1:0] gain_ff [5];
   logic [DIM_W-1:0]  frame_width_ff, flip_height_ff, near_limit_ff;
   reg_index_type     csr_index;
   logic              csr_write;

   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_GAIN_PAIR_CENTRE,
         REG_GAIN_SAME_COLOUR,
         REG_GAIN_ARCTANGENT,
         REG_GAIN_SINGLE_KNOWN,
         REG_GAIN_SINGLE_UNKNOWN: csr_prdata = {8'd0, gain_ff[csr_index]};
         REG_FRAME_WIDTH:         csr_prdata = {20'd0, frame_width_ff};
         REG_FLIP_HEIGHT:         csr_prdata = {20'd0, flip_height_ff};
         default:                 csr_prdata = {20'd0, near_limit_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0]     <= 24'd5872;
         gain_ff[1]     <= 24'd8389;
         gain_ff[2]     <= 24'd3019899;
         gain_ff[3]     <= 24'd168;
         gain_ff[4]     <= 24'd168;
         frame_width_ff <= 12'd640;
         flip_height_ff <= 12'd480;
         near_limit_ff  <= 12'd70;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GAIN_PAIR_CENTRE,
            REG_GAIN_SAME_COLOUR,
            REG_GAIN_ARCTANGENT,
            REG_GAIN_SINGLE_KNOWN,
            REG_GAIN_SINGLE_UNKNOWN: gain_ff[csr_index] <= csr_pwdata[GAIN_W-1:0];
            REG_FRAME_WIDTH:         frame_width_ff <= csr_pwdata[DIM_W-1:0];
            REG_FLIP_HEIGHT:         flip_height_ff <= csr_pwdata[DIM_W-1:0];
            default:                 near_limit_ff  <= csr_pwdata[DIM_W-1:0];
         endcase
      end
   end

   // Sequencer state and datapath registers.
   state_type                 state_ff, state_in;
   frame_type                 frame_ff, frame_in;
   logic                      known_ff, known_in, left_ff, left_in;
   logic [CASE_W-1:0]         case_ff, case_in;
   logic signed [ATAN_W-1:0]  opnd_ff, opnd_in;
   logic [GAIN_W-1:0]         gain_sel_ff, gain_sel_in;
   logic [4:0]                shift_ff, shift_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   result_type                result_ff, result_in;

   logic req_fire, rsp_fire, cordic_start, cordic_done;
   logic signed [ATAN_W-1:0] cordic_angle;

   // Frame decode, all from the captured frame.
   logic b0, b1, y0, y1;
   logic signed [ATAN_W-1:0] w_s, pair_d, blue_d, flip_d, near_s;
   logic signed [ATAN_W-1:0] single_x, single_d;
   logic signed [COORD_W:0]  yellow_dx, yellow_dy;
   logic signed [GAIN_W-1:0] atan_den;
   logic                     toward_edge, single_blue;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      b0 = |{frame_ff.blue_first_x, frame_ff.blue_first_y};
      b1 = |{frame_ff.blue_second_x, frame_ff.blue_second_y};
      y0 = |{frame_ff.yellow_first_x, frame_ff.yellow_first_y};
      y1 = |{frame_ff.yellow_second_x, frame_ff.yellow_second_y};
      w_s    = ATAN_W'({frame_width_ff, 4'd0});
      pair_d = w_s - ATAN_W'(frame_ff.blue_first_x) - ATAN_W'(frame_ff.yellow_first_x);
      blue_d = ATAN_W'(frame_ff.blue_first_x) - ATAN_W'(frame_ff.blue_second_x);
      flip_d = ATAN_W'({flip_height_ff, 4'd0}) - ATAN_W'(frame_ff.blue_first_y);
      near_s = ATAN_W'({near_limit_ff, 4'd0});
      yellow_dx = (COORD_W+1)'(frame_ff.yellow_first_x)
                - (COORD_W+1)'(frame_ff.yellow_second_x);
      yellow_dy = (COORD_W+1)'(frame_ff.yellow_first_y)
                - (COORD_W+1)'(frame_ff.yellow_second_y);
      // Times one hundred as (64 + 32 + 4) times dy.
      atan_den  = (GAIN_W'(yellow_dy) <<< 6) + (GAIN_W'(yellow_dy) <<< 5)
                + (GAIN_W'(yellow_dy) <<< 2);
      single_blue = b0;
      single_x = single_blue ? ATAN_W'(frame_ff.blue_first_x)
                             : ATAN_W'(frame_ff.yellow_first_x);
      // With the side known, a blue cone steers toward the edge when yellow
      // is on the left, a yellow cone when it is not.
      if (known_ff) begin
         toward_edge = single_blue ? left_ff : !left_ff;
      end else begin
         toward_edge = (single_x <<< 1) > w_s;
      end
      single_d = toward_edge ? (w_s - single_x) : -single_x;
   end

   // A second blue cone without a first one does not keep the frame out of
   // the two yellow cone case.
   assign cordic_start = (state_ff == S_SETUP) && !b0 && y0 && y1
                         && yellow_dy != '0 && yellow_dx != '0;

   cpse_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .num   (yellow_dx),
      .den   (atan_den),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   // Rounding to nearest with ties away from zero, then saturation.
   logic [PROD_W-1:0] mag, mag_rnd;
   logic [PROD_W-1:0] half;
   logic signed [ANGLE_W-1:0] angle_sat;

   always_comb begin
      mag     = prod_ff < 0 ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      half    = PROD_W'(1) << (shift_ff - 5'd1);
      mag_rnd = (mag + half) >> shift_ff;
      if (prod_ff < 0) begin
         angle_sat = (mag_rnd >= PROD_W'(1 << ANGLE_FRAC_BITS))
                   ? ANGLE_W'(-(1 << ANGLE_FRAC_BITS)) : ANGLE_W'(-mag_rnd);
      end else begin
         angle_sat = (mag_rnd >= PROD_W'(1 << ANGLE_FRAC_BITS))
                   ? ANGLE_W'((1 << ANGLE_FRAC_BITS) - 1) : ANGLE_W'(mag_rnd);
      end
   end

   always_comb begin
      state_in    = state_ff;
      frame_in    = frame_ff;
      known_in    = known_ff;
      left_in     = left_ff;
      case_in     = case_ff;
      opnd_in     = opnd_ff;
      gain_sel_in = gain_sel_ff;
      shift_in    = shift_ff;
      prod_in     = prod_ff;
      result_in   = result_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               frame_in = {req_ch.blue_first_x, req_ch.blue_first_y,
                           req_ch.blue_second_x, req_ch.blue_second_y,
                           req_ch.yellow_first_x, req_ch.yellow_first_y,
                           req_ch.yellow_second_x, req_ch.yellow_second_y};
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            opnd_in  = '0;
            shift_in = 5'(COORD_FRAC_BITS + GAIN_FRAC_BITS - ANGLE_FRAC_BITS);
            state_in = S_MUL;
            if (b0 && y0) begin
               case_in     = CASE_BOTH;
               known_in    = 1'b1;
               left_in     = frame_ff.yellow_first_x < frame_ff.blue_first_x;
               opnd_in     = pair_d;
               gain_sel_in = gain_ff[REG_GAIN_PAIR_CENTRE];
               shift_in    = 5'(COORD_FRAC_BITS + 1 + GAIN_FRAC_BITS - ANGLE_FRAC_BITS);
            end else if (b0 && b1) begin
               case_in     = CASE_TWO_BLUE;
               gain_sel_in = gain_ff[REG_GAIN_SAME_COLOUR];
               if (frame_ff.blue_first_y != frame_ff.blue_second_y && flip_d >= near_s) begin
                  opnd_in = blue_d;
               end
            end else if (y0 && y1) begin
               case_in     = CASE_TWO_YELLOW;
               gain_sel_in = gain_ff[REG_GAIN_ARCTANGENT];
               shift_in    = 5'(ATAN_FRAC_BITS + GAIN_FRAC_BITS - ANGLE_FRAC_BITS);
               if (cordic_start) begin
                  state_in = S_CORDIC;
               end
            end else if (b0 || y0) begin
               case_in     = b0 ? CASE_BLUE_ONLY : CASE_YELLOW_ONLY;
               gain_sel_in = known_ff ? gain_ff[REG_GAIN_SINGLE_KNOWN]
                                      : gain_ff[REG_GAIN_SINGLE_UNKNOWN];
               opnd_in     = single_d;
            end else begin
               case_in     = CASE_NONE;
            end
         end
         S_CORDIC: begin
            if (cordic_done) begin
               opnd_in  = cordic_angle;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(opnd_ff) * PROD_W'($signed({1'b0, gain_sel_ff}));
            state_in = S_ROUND;
         end
         S_ROUND: begin
            result_in.steer_angle = angle_sat;
            result_in.case_taken  = case_ff;
            state_in = S_DONE;
         end
         default: begin
            if (rsp_fire) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         known_ff <= 1'b0;
         left_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         known_ff <= known_in;
         left_ff  <= left_in;
      end
      frame_ff    <= frame_in;
      case_ff     <= case_in;
      opnd_ff     <= opnd_in;
      gain_sel_ff <= gain_sel_in;
      shift_ff    <= shift_in;
      prod_ff     <= prod_in;
      result_ff   <= result_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = (state_ff == S_DONE);
   assign rsp_ch.steer_angle = result_ff.steer_angle;
   assign rsp_ch.case_taken  = result_ff.case_taken;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready) else $error("Frame taken while busy");
   a_case_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.case_taken <= CASE_NONE) else $error("Illegal case code");
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.case_taken == CASE_NONE |-> rsp_ch.steer_angle == '0)
      else $error("No cone but nonzero angle");
   a_cordic_in_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == S_CORDIC) else $error("Stray CORDIC completion");
   a_side_learnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SETUP && b0 && y0 |=> known_ff) else $error("Side not learnt");
endmodule
`default_nettype wire

// File: verif/steer_checker.sv
// Checker for the cone pair steering estimator: watches the frame, result and
// register ports, predicts each steering result and compares it field by field.
// Depends on cpse_pkg and cpse_if.
`default_nettype none
module steer_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   cpse_req_if                              req_ch,
   cpse_rsp_if                              rsp_ch,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic                        csr_pready,
   input  wire logic [cpse_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output int                               fail_count,
   output int                               pending,
   output int                               frames_checked
);
   import cpse_pkg::*;

   localparam logic [23:0] DEFAULTS [8] = '{24'd5872, 24'd8389, 24'd3019899, 24'd168,
                                            24'd168, 24'd640, 24'd480, 24'd70};
   localparam longint ATAN_TABLE [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                          512, 256, 128, 64, 32, 16, 8, 4, 2};

   logic [23:0] settings [8];
   logic        side_learnt;
   logic        yellow_left;
   result_type  angle_due [$];

   // Round to nearest with ties away from zero, then clamp to +/-1.0.
   function automatic longint round_clamp(input longint v, input int s);
      longint m;
      longint lim;
      m   = (v < 0) ? -v : v;
      lim = longint'(1) << ANGLE_FRAC_BITS;
      if (s > 0) m = (m + (longint'(1) << (s - 1))) >>> s;
      if (v < 0) return (m >= lim) ? -lim : -m;
      return (m >= lim) ? lim - 1 : m;
   endfunction

   function automatic longint cordic_angle(input longint num, input longint den);
      longint x, y, z, xs, ys;
      z = 0;
      if (num == 0 || den == 0) return 0;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      x = den <<< CORDIC_PRESCALE;
      y = num <<< CORDIC_PRESCALE;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN_TABLE[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TABLE[i];
         end
      end
      return z;
   endfunction

   function automatic longint lone_cone(input longint x, input logic to_edge,
                                        input logic [23:0] gain);
      longint w, d;
      w = longint'(settings[REG_FRAME_WIDTH]) <<< COORD_FRAC_BITS;
      d = to_edge ? (w - x) : -x;
      return round_clamp(d * longint'(gain), COORD_FRAC_BITS + GAIN_FRAC_BITS - ANGLE_FRAC_BITS);
   endfunction

   // Works out the steering result of one frame and updates the learnt side.
   function automatic result_type steer_for(input frame_type f);
      longint bx0, by0, bx1, by1, yx0, yy0, yx1, yy1, w, ang;
      logic b0, b1, y0, y1;
      case_code_type code;
      result_type r;
      bx0 = f.blue_first_x;   by0 = f.blue_first_y;
      bx1 = f.blue_second_x;  by1 = f.blue_second_y;
      yx0 = f.yellow_first_x; yy0 = f.yellow_first_y;
      yx1 = f.yellow_second_x; yy1 = f.yellow_second_y;
      b0 = (bx0 != 0 || by0 != 0); b1 = (bx1 != 0 || by1 != 0);
      y0 = (yx0 != 0 || yy0 != 0); y1 = (yx1 != 0 || yy1 != 0);
      w   = longint'(settings[REG_FRAME_WIDTH]) <<< COORD_FRAC_BITS;
      ang = 0;
      if (b0 && y0) begin
         code        = CASE_BOTH;
         yellow_left = (yx0 < bx0);
         side_learnt = 1'b1;
         ang = round_clamp((w - (bx0 + yx0)) * longint'(settings[REG_GAIN_PAIR_CENTRE]),
                           COORD_FRAC_BITS + 1 + GAIN_FRAC_BITS - ANGLE_FRAC_BITS);
      end else if (b0 && b1) begin
         code = CASE_TWO_BLUE;
         if (by0 != by1 && ((longint'(settings[REG_FLIP_HEIGHT]) <<< COORD_FRAC_BITS) - by0) >=
             (longint'(settings[REG_NEAR_LIMIT]) <<< COORD_FRAC_BITS))
            ang = round_clamp((bx0 - bx1) * longint'(settings[REG_GAIN_SAME_COLOUR]),
                              COORD_FRAC_BITS + GAIN_FRAC_BITS - ANGLE_FRAC_BITS);
      end else if (y0 && y1) begin
         code = CASE_TWO_YELLOW;
         if (yy0 != yy1)
            ang = round_clamp(cordic_angle(yx0 - yx1, ATAN_DIVISOR * (yy0 - yy1)) *
                              longint'(settings[REG_GAIN_ARCTANGENT]), GAIN_FRAC_BITS);
      end else if (b0) begin
         code = CASE_BLUE_ONLY;
         if (side_learnt) ang = lone_cone(bx0, yellow_left, settings[REG_GAIN_SINGLE_KNOWN]);
         else ang = lone_cone(bx0, 2 * bx0 > w, settings[REG_GAIN_SINGLE_UNKNOWN]);
      end else if (y0) begin
         code = CASE_YELLOW_ONLY;
         if (side_learnt) ang = lone_cone(yx0, !yellow_left, settings[REG_GAIN_SINGLE_KNOWN]);
         else ang = lone_cone(yx0, 2 * yx0 > w, settings[REG_GAIN_SINGLE_UNKNOWN]);
      end else begin
         code = CASE_NONE;
      end
      r.steer_angle = ang[ANGLE_W-1:0];
      r.case_taken  = code;
      return r;
   endfunction

   always @(posedge clock) begin
      frame_type  f;
      result_type seen, want;
      logic [2:0] idx;
      if (reset) begin
         for (int i = 0; i < 8; i++) settings[i] = DEFAULTS[i];
         side_learnt = 1'b0;
         yellow_left = 1'b0;
         angle_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idx = csr_paddr[4:2];
            settings[idx] = (idx <= REG_GAIN_SINGLE_UNKNOWN) ? csr_pwdata[23:0]
                                                             : {12'd0, csr_pwdata[11:0]};
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.steer_angle = rsp_ch.steer_angle;
            seen.case_taken  = rsp_ch.case_taken;
            if (angle_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: angle %0d case %0d",
                           seen.steer_angle, seen.case_taken);
            end else begin
               want = angle_due.pop_front();
               frames_checked++;
               if (seen.steer_angle !== want.steer_angle) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("steer_angle mismatch: expected %0d, got %0d",
                              want.steer_angle, seen.steer_angle);
               end
               if (seen.case_taken !== want.case_taken) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("case_taken mismatch: expected %0d, got %0d",
                              want.case_taken, seen.case_taken);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            f = {req_ch.blue_first_x, req_ch.blue_first_y, req_ch.blue_second_x,
                 req_ch.blue_second_y, req_ch.yellow_first_x, req_ch.yellow_first_y,
                 req_ch.yellow_second_x, req_ch.yellow_second_y};
            angle_due.push_back(steer_for(f));
         end
      end
      pending = angle_due.size();
   end

   initial begin
      fail_count     = 0;
      pending        = 0;
      frames_checked = 0;
   end
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Top of the cone pair steering estimator testbench: clock, reset, frame and
// register stimulus, receiver back-pressure and the final verdict.
// Depends on cpse_pkg, cpse_if, the design and steer_checker.
`default_nettype none
module tb_top;
   import cpse_pkg::*;

   logic               clock;
   logic               reset;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [ADDR_W-1:0]  csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   int                 fail_count;
   int                 pending;
   int                 frames_checked;
   int                 frames_sent;
   int                 settings_used;
   // When calm is set neither side idles, giving a stretch at full rate.
   logic               calm;
   // A request from the sender for the receiver to hold off for a long stretch.
   logic               hold_request;

   cpse_req_if req_ch ();
   cpse_rsp_if rsp_ch ();

   cone_pair_steering_estimator uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   steer_checker checker_inst (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending), .frames_checked(frames_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Absolute limit on the run, far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("timeout with %0d results outstanding", pending);
      $display("[FAIL] regression broken");
      $finish;
   end

   // The receiver stalls at random, and on request holds off for a long
   // stretch so that the block fills up and refuses further frames.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         rsp_ch.ready <= 1'b0;
         repeat (300) @(posedge clock);
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 29);
      end
   end

   // A register write has a setup phase and then an access phase.
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Lets the block drain, waits out the longest latency, then loads all eight
   // registers so that every setting starts from a quiet block.
   task automatic load_settings(input logic [23:0] g [5], input logic [11:0] width,
                                input logic [11:0] height, input logic [11:0] near);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      write_register(REG_GAIN_PAIR_CENTRE, g[0]);
      write_register(REG_GAIN_SAME_COLOUR, g[1]);
      write_register(REG_GAIN_ARCTANGENT, g[2]);
      write_register(REG_GAIN_SINGLE_KNOWN, g[3]);
      write_register(REG_GAIN_SINGLE_UNKNOWN, g[4]);
      write_register(REG_FRAME_WIDTH, width);
      write_register(REG_FLIP_HEIGHT, height);
      write_register(REG_NEAR_LIMIT, near);
      settings_used++;
   endtask

   // Offers one frame and holds it until the block takes it. Valid is only
   // lowered at the start of an idle gap, never in the step it is raised.
   task automatic send_frame(input frame_type f);
      if (!calm && $urandom_range(99) < 29) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 29);
      end
      req_ch.valid           <= 1'b1;
      req_ch.blue_first_x    <= f.blue_first_x;
      req_ch.blue_first_y    <= f.blue_first_y;
      req_ch.blue_second_x   <= f.blue_second_x;
      req_ch.blue_second_y   <= f.blue_second_y;
      req_ch.yellow_first_x  <= f.yellow_first_x;
      req_ch.yellow_first_y  <= f.yellow_first_y;
      req_ch.yellow_second_x <= f.yellow_second_x;
      req_ch.yellow_second_y <= f.yellow_second_y;
      do @(posedge clock); while (!req_ch.ready);
      frames_sent++;
   endtask

   // Coordinates are either anywhere in the field or inside a typical frame,
   // with the occasional zero in one axis.
   function automatic logic [15:0] coordinate();
      case ($urandom_range(9))
         0:       return 16'd0;
         1, 2, 3: return 16'($urandom_range(65535));
         default: return 16'($urandom_range(12000));
      endcase
   endfunction

   // A random frame: each cone present or absent at random, with pairs often
   // level or vertically aligned so that the zero-angle branches are reached.
   function automatic frame_type random_frame();
      frame_type f;
      f = '0;
      if ($urandom_range(1)) begin f.blue_first_x = coordinate(); f.blue_first_y = coordinate(); end
      if ($urandom_range(1)) begin f.blue_second_x = coordinate(); f.blue_second_y = coordinate(); end
      if ($urandom_range(1)) begin f.yellow_first_x = coordinate(); f.yellow_first_y = coordinate(); end
      if ($urandom_range(1)) begin f.yellow_second_x = coordinate(); f.yellow_second_y = coordinate(); end
      if ($urandom_range(99) < 15) f.blue_second_y = f.blue_first_y;
      if ($urandom_range(99) < 15) f.yellow_second_y = f.yellow_first_y;
      if ($urandom_range(99) < 10) f.yellow_second_x = f.yellow_first_x;
      return f;
   endfunction

   function automatic frame_type cones(input logic [15:0] bx0, by0, bx1, by1,
                                       input logic [15:0] yx0, yy0, yx1, yy1);
      return {bx0, by0, bx1, by1, yx0, yy0, yx1, yy1};
   endfunction

   initial begin
      logic [23:0] gains [5];
      reset          = 1'b1;
      calm           = 1'b0;
      hold_request   = 1'b0;
      frames_sent    = 0;
      settings_used  = 1;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      req_ch.valid   = 1'b0;
      req_ch.blue_first_x = '0;    req_ch.blue_first_y = '0;
      req_ch.blue_second_x = '0;   req_ch.blue_second_y = '0;
      req_ch.yellow_first_x = '0;  req_ch.yellow_first_y = '0;
      req_ch.yellow_second_x = '0; req_ch.yellow_second_y = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset settings. The single cone cases come
      // first, while the side of the yellow cones is still unknown.
      send_frame(cones(0, 0, 0, 0, 0, 0, 0, 0));                    // no cones
      send_frame(cones(16'd2000, 16'd100, 0, 0, 0, 0, 0, 0));       // blue, left half
      send_frame(cones(16'd9000, 16'd100, 0, 0, 0, 0, 0, 0));       // blue, right half
      send_frame(cones(0, 0, 0, 0, 16'd5120, 16'd1, 0, 0));         // yellow, exactly centre
      send_frame(cones(0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0));      // yellow at the far corner
      send_frame(cones(0, 0, 16'd300, 16'd300, 0, 0, 16'd40, 16'd7)); // second cones alone
      send_frame(cones(16'd3000, 16'd4000, 16'd5000, 16'd2000, 0, 0, 0, 0)); // two blue
      send_frame(cones(16'd3000, 16'd4000, 16'd5000, 16'd4000, 0, 0, 0, 0)); // two blue, level
      send_frame(cones(16'd3000, 16'd7000, 16'd5000, 16'd2000, 0, 0, 0, 0)); // two blue, near
      send_frame(cones(16'hFFFF, 16'd1, 16'd0, 16'd2, 0, 0, 0, 0)); // two blue, full swing
      send_frame(cones(0, 0, 0, 0, 16'd4000, 16'd3000, 16'd2000, 16'd1000)); // two yellow
      send_frame(cones(0, 0, 0, 0, 16'd4000, 16'd3000, 16'd2000, 16'd3000)); // yellow level
      send_frame(cones(0, 0, 0, 0, 16'd4000, 16'd3000, 16'd4000, 16'd1000)); // no x change
      send_frame(cones(0, 0, 0, 0, 16'hFFFF, 16'd1, 16'd0, 16'd2)); // steepest yellow pair
      send_frame(cones(16'd8000, 16'd500, 0, 0, 16'd2000, 16'd500, 0, 0)); // yellow on left
      send_frame(cones(16'd8000, 16'd500, 0, 0, 0, 0, 0, 0));       // blue, side known
      send_frame(cones(0, 0, 0, 0, 16'd2000, 16'd500, 0, 0));       // yellow, side known
      send_frame(cones(16'd2000, 16'd500, 0, 0, 16'd8000, 16'd500, 0, 0)); // yellow on right
      send_frame(cones(16'd2000, 16'd500, 0, 0, 0, 0, 0, 0));
      send_frame(cones(0, 0, 0, 0, 16'd8000, 16'd500, 0, 0));
      send_frame(cones(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));  // every field at its top
      send_frame(cones(16'd1, 0, 0, 0, 0, 16'd1, 0, 0));           // least present cones

      // Random frames over five settings: the largest values, the smallest,
      // two random ones and finally the reset values again.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               gains = '{default: 24'hFFFFFF};
               load_settings(gains, 12'hFFF, 12'hFFF, 12'hFFF);
            end
            1: begin
               gains = '{default: 24'd0};
               load_settings(gains, 12'd1, 12'd1, 12'd0);
            end
            4: begin
               gains = '{24'd5872, 24'd8389, 24'd3019899, 24'd168, 24'd168};
               load_settings(gains, 12'd640, 12'd480, 12'd70);
            end
            default: begin
               foreach (gains[i]) gains[i] = 24'($urandom_range(24'hFFFFFF) >> $urandom_range(23));
               load_settings(gains, 12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1)),
                             12'($urandom_range(4095)));
            end
         endcase
         for (int n = 0; n < 140; n++) begin
            // In the last phase: a full-rate stretch, one long receiver hold
            // while frames are still offered, and one full drain.
            if (phase == 4) begin
               calm = (n >= 20 && n < 70);
               if (n == 80) hold_request = 1'b1;
               if (n == 110) begin
                  req_ch.valid <= 1'b0;
                  @(posedge clock);
                  while (pending != 0) @(posedge clock);
               end
            end
            send_frame(random_frame());
         end
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("%0d frames sent and %0d results checked under %0d register settings",
               frames_sent, frames_checked, settings_used);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire

// File: cone_pair_steering_estimator.f
design/cpse_pkg.sv
design/cpse_if.sv
design/cpse_cordic.sv
design/cone_pair_steering_estimator.sv
verif/steer_checker.sv
verif/tb_top.sv
